[hdl/csrb_pkg.sv]
// shared types, codes and defaults for the counter sample ring buffer
`default_nettype none

package csrb_pkg;

  localparam int DEF_RING_DEPTH = 1024;
  localparam int DEF_NUM_EVENTS = 4;

  // event fields carried on one poll beat
  localparam int IN_EVENTS = 4;

  localparam logic [31:0] PERIOD_RESET = 32'd1000;
  localparam logic [2:0]  ACTIVE_RESET = 3'd4;

  // command codes
  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register index, taken from the word address
  localparam logic REG_SAMPLE_PERIOD   = 1'b0;
  localparam logic REG_ACTIVE_COUNTERS = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic sweep;       // clearing pass after reset
    logic capture;     // latch poll fields
    logic rd_issue;    // read oldest slot, drop its mark
    logic sample;      // poll evaluation cycle
    logic ovf_clear;   // wipe write slot and set its mark
    logic rd_advance;  // move read pointer on
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic ovf;
  } ctl_sts_t;

endpackage

`default_nettype wire

[hdl/csrb_ctrl.sv]
// control state machine of the counter sample ring buffer
`default_nettype none

module csrb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              command,
  input  wire csrb_pkg::ctl_sts_t sts,
  output csrb_pkg::ctl_cmd_t     cmd,
  output logic                   busy,
  output logic                   result_valid
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POLL,
    S_OVF,
    S_READ
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      busy         <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.sweep_last) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            if (command == csrb_pkg::CMD_READ) begin
              state        <= S_READ;
              result_valid <= 1'b1;
            end else begin
              state <= S_POLL;
            end
          end
        end
        S_POLL: begin
          if (sts.ovf) begin
            state <= S_OVF;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_OVF: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        S_READ: begin
          state        <= S_IDLE;
          busy         <= 1'b0;
          result_valid <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.sweep      = (state == S_CLEAR);
    cmd.capture    = (state == S_IDLE) && start;
    cmd.rd_issue   = (state == S_IDLE) && start && (command == csrb_pkg::CMD_READ);
    cmd.sample     = (state == S_POLL);
    cmd.ovf_clear  = (state == S_OVF);
    cmd.rd_advance = (state == S_READ);
  end

endmodule

`default_nettype wire

[hdl/csrb_datapath.sv]
// ring memories, pointers and sample logic of the counter sample ring buffer
`default_nettype none

module csrb_datapath #(
  parameter int RING_DEPTH = csrb_pkg::DEF_RING_DEPTH,
  parameter int NUM_EVENTS = csrb_pkg::DEF_NUM_EVENTS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire csrb_pkg::ctl_cmd_t cmd,
  output csrb_pkg::ctl_sts_t     sts,
  input  wire logic [31:0]       sample_period,
  input  wire logic [2:0]        active_counters,
  input  wire logic [31:0]       cycle_count,
  input  wire logic              overflow_seen,
  input  wire logic [31:0]       event_a,
  input  wire logic [31:0]       event_b,
  input  wire logic [31:0]       event_c,
  input  wire logic [31:0]       event_d,
  output logic [31:0]            rec_cycles,
  output logic [31:0]            rec_event_a,
  output logic [31:0]            rec_event_b,
  output logic [31:0]            rec_event_c,
  output logic [31:0]            rec_event_d,
  output logic [2:0]             rec_active,
  output logic                   rec_reset_mark
);

  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int NUM_LANES = (NUM_EVENTS < csrb_pkg::IN_EVENTS) ? NUM_EVENTS
                                                                : csrb_pkg::IN_EVENTS;
  localparam logic [PTR_W-1:0] LAST     = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] RESET_WP = PTR_W'(1 % RING_DEPTH);
  localparam logic [3:0]       NE4      = 4'(NUM_EVENTS);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] sweep_cnt;
  logic [31:0]      last_time;

  // latched poll beat
  logic [31:0] cyc_q;
  logic        ovf_q;
  logic [31:0] ev_q [csrb_pkg::IN_EVENTS];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cyc_q    <= cycle_count;
      ovf_q    <= overflow_seen;
      ev_q[0]  <= event_a;
      ev_q[1]  <= event_b;
      ev_q[2]  <= event_c;
      ev_q[3]  <= event_d;
    end
  end

  logic [3:0]       act_sat;
  logic             sample_hit;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] wp_prev;

  always_comb begin
    act_sat    = ({1'b0, active_counters} > NE4) ? NE4 : {1'b0, active_counters};
    sample_hit = cmd.sample && ((cyc_q - last_time) >= sample_period);
    wp_inc     = next_slot(wp);
    wp_prev    = (wp == '0) ? LAST : wp - 1'b1;
  end

  assign sts.sweep_last = (sweep_cnt == LAST);
  assign sts.ovf        = ovf_q;

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= RESET_WP;
      rp        <= '0;
      last_time <= '0;
      sweep_cnt <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= next_slot(sweep_cnt);
      end
      if (sample_hit) begin
        wp        <= wp_inc;
        last_time <= cyc_q;
        if (rp == wp_inc) begin
          rp <= next_slot(wp_inc);
        end
      end
      if (cmd.rd_advance && (rp != wp_prev)) begin
        rp <= next_slot(rp);
      end
    end
  end

  // shared write address: sweep slot, read slot or write slot
  logic [PTR_W-1:0] waddr;
  logic             slot_we;

  always_comb begin
    priority if (cmd.sweep) begin
      waddr = sweep_cnt;
    end else if (cmd.rd_issue) begin
      waddr = rp;
    end else begin
      waddr = wp;
    end
    slot_we = cmd.sweep || cmd.ovf_clear || sample_hit;
  end

  // cycle and active stores
  logic [31:0] cycle_mem  [RING_DEPTH];
  logic [2:0]  active_mem [RING_DEPTH];
  logic        mark_mem   [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (slot_we) begin
      cycle_mem[waddr]  <= sample_hit ? cyc_q : 32'd0;
      active_mem[waddr] <= sample_hit ? act_sat[2:0] : 3'd0;
    end
    if (cmd.rd_issue) begin
      rec_cycles <= cycle_mem[rp];
      rec_active <= active_mem[rp];
    end
  end

  // marker store: set on reset slot and on overflow, dropped once read
  logic mark_we;
  logic mark_wdata;

  always_comb begin
    mark_we    = cmd.sweep || cmd.ovf_clear || cmd.rd_issue;
    mark_wdata = cmd.sweep ? (sweep_cnt == RESET_WP) : cmd.ovf_clear;
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[waddr] <= mark_wdata;
    end
    if (cmd.rd_issue) begin
      rec_reset_mark <= mark_mem[rp];
    end
  end

  // one event store per lane
  logic [31:0] ev_rd  [NUM_LANES];
  logic [31:0] ev_out [csrb_pkg::IN_EVENTS];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic [31:0] ev_mem [RING_DEPTH];
    logic        lane_we;

    assign lane_we = cmd.sweep || cmd.ovf_clear || (sample_hit && (4'(g) < act_sat));

    always_ff @(posedge clk) begin
      if (lane_we) begin
        ev_mem[waddr] <= sample_hit ? ev_q[g] : 32'd0;
      end
      if (cmd.rd_issue) begin
        ev_rd[g] <= ev_mem[rp];
      end
    end
  end

  for (genvar k = 0; k < csrb_pkg::IN_EVENTS; k++) begin : g_out
    if (k < NUM_LANES) begin : g_have
      assign ev_out[k] = ev_rd[k];
    end else begin : g_none
      assign ev_out[k] = 32'd0;
    end
  end

  assign rec_event_a = ev_out[0];
  assign rec_event_b = ev_out[1];
  assign rec_event_c = ev_out[2];
  assign rec_event_d = ev_out[3];

endmodule

`default_nettype wire

[hdl/counter_sample_ring_buffer_unit.sv]
// top level of the counter sample ring buffer: register port, controller, datapath
// a poll beat passes through the poll state, and also through the wipe state when it carries an overflow (slot wipe)
// a read beat gives its record in the cycle after acceptance, strobed by result_valid for
// one cycle; busy drops with the strobe (one ring port)
// the receiver cannot stall, so a result is never held back
// after reset a clearing pass writes every one of the RING_DEPTH slots, one per cycle,
// with busy high until the pass ends; register writes are taken throughout
`default_nettype none

module counter_sample_ring_buffer_unit #(
  parameter int RING_DEPTH = csrb_pkg::DEF_RING_DEPTH,
  parameter int NUM_EVENTS = csrb_pkg::DEF_NUM_EVENTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command beat
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [31:0] cycle_count,
  input  wire logic        overflow_seen,
  input  wire logic [31:0] event_a,
  input  wire logic [31:0] event_b,
  input  wire logic [31:0] event_c,
  input  wire logic [31:0] event_d,
  // result beat
  output logic             result_valid,
  output logic [31:0]      rec_cycles,
  output logic [31:0]      rec_event_a,
  output logic [31:0]      rec_event_b,
  output logic [31:0]      rec_event_c,
  output logic [31:0]      rec_event_d,
  output logic [2:0]       rec_active,
  output logic             rec_reset_mark,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] sample_period;
  logic [2:0]  active_counters;
  logic        cfg_wr;

  // registers sit at word addresses, the byte offset bits are ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period   <= csrb_pkg::PERIOD_RESET;
      active_counters <= csrb_pkg::ACTIVE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == csrb_pkg::REG_SAMPLE_PERIOD) begin
        sample_period <= pwdata;
      end else begin
        active_counters <= pwdata[2:0];
      end
    end
  end

  // read back
  always_comb begin
    unique case (paddr[2])
      csrb_pkg::REG_SAMPLE_PERIOD:   prdata = sample_period;
      csrb_pkg::REG_ACTIVE_COUNTERS: prdata = {29'd0, active_counters};
    endcase
  end

  csrb_pkg::ctl_cmd_t ctl_cmd;
  csrb_pkg::ctl_sts_t ctl_sts;

  // sequencing of sweep, poll and read beats
  csrb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .sts          (ctl_sts),
    .cmd          (ctl_cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  // ring storage and pointer arithmetic
  csrb_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .NUM_EVENTS (NUM_EVENTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (ctl_cmd),
    .sts             (ctl_sts),
    .sample_period   (sample_period),
    .active_counters (active_counters),
    .cycle_count     (cycle_count),
    .overflow_seen   (overflow_seen),
    .event_a         (event_a),
    .event_b         (event_b),
    .event_c         (event_c),
    .event_d         (event_d),
    .rec_cycles      (rec_cycles),
    .rec_event_a     (rec_event_a),
    .rec_event_b     (rec_event_b),
    .rec_event_c     (rec_event_c),
    .rec_event_d     (rec_event_d),
    .rec_active      (rec_active),
    .rec_reset_mark  (rec_reset_mark)
  );

endmodule

`default_nettype wire

[verif/counter_sample_ring_buffer_unit_tb.sv]
// self-checking testbench for the counter sample ring buffer unit
`timescale 1ns / 1ps

module counter_sample_ring_buffer_unit_tb;
  import csrb_pkg::*;

  localparam int RING = DEF_RING_DEPTH;
  localparam int NEV  = DEF_NUM_EVENTS;

  // one command beat as offered on the input ports, events[0] is event_a
  typedef struct packed {
    logic             cmd;
    logic [31:0]      cycles;
    logic             ovf;
    logic [3:0][31:0] events;
  } beat_t;

  // one record as seen on the result ports, events[0] is rec_event_a
  typedef struct packed {
    logic [31:0]      cycles;
    logic [3:0][31:0] events;
    logic [2:0]       active;
    logic             mark;
  } record_t;

  // mirror of the sample ring plus the queue of records still owed by the block
  class ring_record_board;
    logic [31:0] cyc_mem [RING];
    logic [31:0] evt_mem [RING][NEV];
    logic [2:0]  act_mem [RING];
    logic        mark_mem [RING];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    logic [31:0] last_stamp;
    logic [31:0] period;
    logic [2:0]  active;
    bit          push_seen;
    record_t     pending[$];
    int          mismatches;

    function new();
      for (int s = 0; s < RING; s++) begin
        cyc_mem[s]  = '0;
        act_mem[s]  = '0;
        mark_mem[s] = 1'b0;
        for (int e = 0; e < NEV; e++) evt_mem[s][e] = '0;
      end
      wr_ptr = 1 % RING;
      rd_ptr = 0;
      mark_mem[wr_ptr] = 1'b1;
      last_stamp = '0;
      period     = PERIOD_RESET;
      active     = ACTIVE_RESET;
      push_seen  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_SAMPLE_PERIOD) period = value;
      else active = value[2:0];
    endfunction

    // advance the ring for one accepted beat, queue the record a read owes
    function void note_beat(beat_t b);
      int unsigned wp;
      int unsigned rp;
      int unsigned n;
      int unsigned i;
      record_t     rec;
      wp = wr_ptr;
      rp = rd_ptr;
      if (b.cmd == CMD_POLL) begin
        if (b.cycles - last_stamp >= period) begin
          n = (active > NEV) ? NEV : active;
          cyc_mem[wp] = b.cycles;
          act_mem[wp] = n[2:0];
          // inactive events keep whatever the slot held
          for (i = 0; i < n && i < 4; i++) evt_mem[wp][i] = b.events[i];
          wp = (wp + 1) % RING;
          if (rp == wp) begin
            rp = (wp + 1) % RING;
            push_seen = 1'b1;
          end
          last_stamp = b.cycles;
        end
        if (b.ovf) begin
          cyc_mem[wp] = '0;
          act_mem[wp] = '0;
          mark_mem[wp] = 1'b1;
          for (i = 0; i < NEV; i++) evt_mem[wp][i] = '0;
        end
      end else begin
        rec.cycles = cyc_mem[rp];
        for (i = 0; i < 4; i++) rec.events[i] = (i < NEV) ? evt_mem[rp][i] : '0;
        rec.active = act_mem[rp];
        rec.mark   = mark_mem[rp];
        mark_mem[rp] = 1'b0;
        // held just behind the write slot, modulo the ring
        if (rp != (wp + RING - 1) % RING) rp = (rp + 1) % RING;
        pending.push_back(rec);
      end
      wr_ptr = wp;
      rd_ptr = rp;
    endfunction

    function void check_record(record_t got);
      record_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected record: cyc %h ev %h act %0d mark %b",
                   got.cycles, got.events, got.active, got.mark);
        return;
      end
      want = pending.pop_front();
      if (got.cycles !== want.cycles || got.events !== want.events ||
          got.active !== want.active || got.mark !== want.mark) begin
        mismatches++;
        if (mismatches <= 10)
          $display("record mismatch: expected cyc %h ev %h act %0d mark %b, got cyc %h ev %h act %0d mark %b",
                   want.cycles, want.events, want.active, want.mark,
                   got.cycles, got.events, got.active, got.mark);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [31:0] cycle_count;
  logic        overflow_seen;
  logic [31:0] event_a;
  logic [31:0] event_b;
  logic [31:0] event_c;
  logic [31:0] event_d;
  logic        result_valid;
  logic [31:0] rec_cycles;
  logic [31:0] rec_event_a;
  logic [31:0] rec_event_b;
  logic [31:0] rec_event_c;
  logic [31:0] rec_event_d;
  logic [2:0]  rec_active;
  logic        rec_reset_mark;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ring_record_board books = new();
  bit gaps_on = 1'b1;   // random idle cycles on the command side

  counter_sample_ring_buffer_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // results cannot be held off, so every strobed cycle is a beat
  always @(posedge clk) begin : record_watch
    record_t got;
    if (!rst && result_valid) begin
      got.cycles    = rec_cycles;
      got.events[0] = rec_event_a;
      got.events[1] = rec_event_b;
      got.events[2] = rec_event_c;
      got.events[3] = rec_event_d;
      got.active    = rec_active;
      got.mark      = rec_reset_mark;
      books.check_record(got);
    end
  end

  // mostly random words, with all zeros and all ones mixed in
  function automatic logic [31:0] rand_word();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic beat_t make_poll(logic [31:0] cyc, logic ovf);
    beat_t b;
    b.cmd    = CMD_POLL;
    b.cycles = cyc;
    b.ovf    = ovf;
    for (int e = 0; e < 4; e++) b.events[e] = rand_word();
    return b;
  endfunction

  // poll fields on a read are noise the block must ignore
  function automatic beat_t make_read();
    beat_t b;
    b = make_poll(rand_word(), 1'($urandom_range(1)));
    b.cmd = CMD_READ;
    return b;
  endfunction

  // nine in ten polls reach the period, a few land exactly on it
  function automatic beat_t fill_poll();
    logic [31:0] step;
    if (books.period == 0 || $urandom_range(9) != 0)
      step = books.period + (($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(1, 1000)));
    else
      step = $urandom_range(0, books.period - 1);
    return make_poll(books.last_stamp + step, $urandom_range(9) == 0);
  endfunction

  // offer one beat, hold it until the block takes it, then book it
  task automatic issue(beat_t b);
    while (gaps_on && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    command       <= b.cmd;
    cycle_count   <= b.cycles;
    overflow_seen <= b.ovf;
    event_a       <= b.events[0];
    event_b       <= b.events[1];
    event_c       <= b.events[2];
    event_d       <= b.events[3];
    do @(posedge clk); while (busy);
    books.note_beat(b);
  endtask

  // drain owed records, then let a poll with a slot wipe finish
  task automatic settle();
    start <= 1'b0;
    while (books.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // both registers, back to back; junk in the unused upper bits of the count
  task automatic program_regs(logic [31:0] per, logic [2:0] act);
    for (int r = 0; r < 2; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= (r == 0) ? {REG_SAMPLE_PERIOD, 2'b00} : {REG_ACTIVE_COUNTERS, 2'b00};
      pwdata  <= (r == 0) ? per : {29'($urandom()), act};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (r == 0) books.set_register(REG_SAMPLE_PERIOD, per);
      else books.set_register(REG_ACTIVE_COUNTERS, {29'd0, act});
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // poll-only stretch that walks the write slot up to a bound, or round to slot 0
  task automatic fill_phase(logic [31:0] per, logic [2:0] act, int unsigned bound, bit gaps);
    settle();
    program_regs(per, act);
    gaps_on = gaps;
    while ((bound != 0) ? (books.wr_ptr < bound) : (books.wr_ptr != 0))
      issue(fill_poll());
  endtask

  task automatic mixed_phase(logic [31:0] per, logic [2:0] act, int count);
    settle();
    program_regs(per, act);
    gaps_on = 1'b1;
    repeat (count) begin
      if ($urandom_range(1) == 1)
        issue(make_read());
      else
        issue(make_poll(books.last_stamp + $urandom_range(0, 2 * per + 2),
                        $urandom_range(9) == 0));
    end
  endtask

  initial begin
    beat_t b;
    int    k;
    start         <= 1'b0;
    command       <= CMD_POLL;
    cycle_count   <= '0;
    overflow_seen <= 1'b0;
    event_a       <= '0;
    event_b       <= '0;
    event_c       <= '0;
    event_d       <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst           <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings; reads first, while the read slot sits just behind the write slot
    issue(make_read());
    b = make_read();
    b.cycles = '1;
    b.ovf    = 1'b1;
    b.events = '1;
    issue(b);
    b = make_poll(32'd999, 1'b0);           // one short of the period
    b.events = '1;
    issue(b);
    b = make_poll(32'd1000, 1'b0);          // exactly the period, slot keeps its mark
    b.events = '1;
    issue(b);
    issue(make_poll(32'd1999, 1'b1));       // wipe without a sample
    b = make_poll(32'hFFFF_FFFF, 1'b0);
    b.events = '0;
    issue(b);
    issue(make_poll(32'h0000_03E6, 1'b0));  // wraps past zero, still short
    issue(make_poll(32'h0000_03E7, 1'b1));  // wraps past zero, sample then wipe

    // period zero samples on every poll; oversized count saturates
    settle();
    program_regs(32'd0, 3'd7);
    issue(make_poll(32'h0000_03E7, 1'b0));
    issue(make_poll(32'h0000_03E7, 1'b1));

    // no active events: the wiped slot keeps its zeros
    settle();
    program_regs(32'd0, 3'd0);
    issue(make_poll(rand_word(), 1'b0));

    settle();
    program_regs(32'd1, 3'd2);
    issue(make_poll(books.last_stamp, 1'b0));
    issue(make_poll(books.last_stamp + 32'd1, 1'b0));

    // polls only, so the write slot laps the ring and pushes the read slot at slot 0
    fill_phase(32'd0, 3'd4, 200, 1'b1);
    fill_phase(32'd1, 3'd1, 400, 1'b0);    // long stretch with no idling
    fill_phase(32'd1000, 3'd3, 600, 1'b1);
    fill_phase(32'h8000_0000, 3'd5, 800, 1'b1);
    fill_phase(32'd50, 3'd2, 0, 1'b1);

    // read the whole ring back; polls never reach the largest period, so the
    // write slot stays at 0 and the read slot ends held at the top of the ring
    settle();
    program_regs(32'hFFFF_FFFF, 3'd6);
    gaps_on = 1'b1;
    while (!(books.rd_ptr == RING - 1 && books.wr_ptr == 0)) begin
      if ($urandom_range(15) == 0)
        issue(make_poll(books.last_stamp + $urandom_range(0, 32'hFFFF_FFFE),
                        $urandom_range(3) == 0));
      else
        issue(make_read());
    end
    repeat (3) issue(make_read());

    // second lap: narrow counts leave older events in place
    mixed_phase(32'd3, 3'd1, 70);
    mixed_phase(32'd0, 3'd0, 50);
    mixed_phase(32'd2, 3'd3, 70);

    start <= 1'b0;
    k = 0;
    while (books.pending.size() != 0 && k < 200) begin
      @(posedge clk);
      k++;
    end
    repeat (8) @(posedge clk);
    if (books.mismatches == 0 && books.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
